FILE: design/mtod_pkg.sv
package mtod_pkg;

    localparam int unsigned MS_PER_SECOND = 1000;

    localparam int SEC_W   = 32;
    localparam int MS_W    = 10;
    localparam int MSUM_W  = MS_W + 1;
    localparam int PRE_W   = 20;
    localparam int TOTAL_W = SEC_W + MS_W;
    localparam int MODE_W  = 2;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    // x / 1000 == (x * RECIP_1000) >> DIV_SHIFT for every 32-bit x
    localparam int DIV_SHIFT = 38;
    localparam int RECIP_W   = 29;
    localparam int QUO_W     = SEC_W + RECIP_W - DIV_SHIFT;
    localparam logic [RECIP_W-1:0] RECIP_1000 = 29'd274877907;

    typedef logic [MODE_W-1:0] t_mode;

    localparam t_mode MODE_TICK = 2'd0;
    localparam t_mode MODE_SET  = 2'd1;
    localparam t_mode MODE_ADD  = 2'd2;
    localparam t_mode MODE_READ = 2'd3;

    // register index, taken from paddr[2]
    localparam logic REG_MS_PER_TICK  = 1'b0;
    localparam logic REG_TICKS_PER_MS = 1'b1;

    typedef struct packed {
        logic [MS_W-1:0]  ms_per_tick;
        logic [PRE_W-1:0] ticks_per_ms;
    } t_cfg;

endpackage

FILE: design/mtod_ifs.sv
interface mtod_in_if import mtod_pkg::*; ();
    logic             valid;
    logic             ready;
    t_mode            mode;
    logic [SEC_W-1:0] time_value;
    logic [SEC_W-1:0] add_ms;

    modport source (output valid, mode, time_value, add_ms, input ready);
    modport sink   (input valid, mode, time_value, add_ms, output ready);
endinterface

interface mtod_out_if import mtod_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [SEC_W-1:0]   seconds;
    logic [MS_W-1:0]    millis_part;
    logic [TOTAL_W-1:0] total_ms;

    modport source (output valid, seconds, millis_part, total_ms, input ready);
    modport sink   (input valid, seconds, millis_part, total_ms, output ready);
endinterface

FILE: design/mtod_regs.sv
module mtod_regs import mtod_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    // word aligned map, low address bits ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ms_per_tick  <= MS_W'(1);
            r_cfg.ticks_per_ms <= '0;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_MS_PER_TICK:  r_cfg.ms_per_tick  <= pwdata[MS_W-1:0];
                REG_TICKS_PER_MS: r_cfg.ticks_per_ms <= pwdata[PRE_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MS_PER_TICK:  prdata = APB_DW'(r_cfg.ms_per_tick);
            REG_TICKS_PER_MS: prdata = APB_DW'(r_cfg.ticks_per_ms);
        endcase
    end

endmodule

FILE: design/millisecond_time_of_day_clock.sv
// path of a beat: input register, quotient, remainder, time state, result register
// throughput: one beat per cycle while the output is not stalled; the seconds/millis/prescaler update is one
//   add and compare stage closed on itself, so an item may follow every cycle
// the division of add_ms by one thousand runs in two stages ahead of that loop
// reset (synchronous, active low): time and prescaler cleared, ms_per_tick = 1,
//   ticks_per_ms = 0, pipeline emptied
module millisecond_time_of_day_clock import mtod_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mtod_in_if.sink           i_in,
    mtod_out_if.source        o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    // configuration registers behind the apb port
    t_cfg cfg;

    mtod_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // stage valids; stage 3 is the time state itself
    logic r_v0, r_v1, r_v2, r_v3, r_v4;
    logic rdy0, rdy1, rdy2, rdy3, rdy4;

    // each stage moves on when it is empty or the next one takes its beat,
    // so bubbles close up and input keeps flowing while a result waits, until all stages are full
    assign rdy4 = !r_v4 || o_out.ready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign rdy0 = !r_v0 || rdy1;

    assign i_in.ready = rdy0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy0) r_v0 <= i_in.valid;
            if (rdy1) r_v1 <= r_v0;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    // ---------------------------------------------------------------
    // stage 0: input register
    // ---------------------------------------------------------------
    t_mode            r_s0_mode;
    logic [SEC_W-1:0] r_s0_time;
    logic [SEC_W-1:0] r_s0_add;

    always_ff @(posedge i_clk) begin
        if (rdy0 && i_in.valid) begin
            r_s0_mode <= i_in.mode;
            r_s0_time <= i_in.time_value;
            r_s0_add  <= i_in.add_ms;
        end
    end

    // ---------------------------------------------------------------
    // stage 1: quotient of add_ms by one thousand via the reciprocal
    // ---------------------------------------------------------------
    logic [SEC_W+RECIP_W-1:0] quo_prod;
    t_mode                    r_s1_mode;
    logic [SEC_W-1:0]         r_s1_time;
    logic [MS_W-1:0]          r_s1_add;
    logic [QUO_W-1:0]         r_s1_q;

    assign quo_prod = {{RECIP_W{1'b0}}, r_s0_add} * {{SEC_W{1'b0}}, RECIP_1000};

    always_ff @(posedge i_clk) begin
        if (rdy1 && r_v0) begin
            r_s1_mode <= r_s0_mode;
            r_s1_time <= r_s0_time;
            r_s1_add  <= r_s0_add[MS_W-1:0];
            r_s1_q    <= quo_prod[DIV_SHIFT +: QUO_W];
        end
    end

    // ---------------------------------------------------------------
    // stage 2: remainder; it is below 1024 so ten low bits are enough
    // ---------------------------------------------------------------
    logic [MS_W-1:0]  n_rem;
    t_mode            r_s2_mode;
    logic [SEC_W-1:0] r_s2_time;
    logic [QUO_W-1:0] r_s2_q;
    logic [MS_W-1:0]  r_s2_rem;

    assign n_rem = r_s1_add
                 - MS_W'(r_s1_q[MS_W-1:0] * MS_W'(MS_PER_SECOND));

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) begin
            r_s2_mode <= r_s1_mode;
            r_s2_time <= r_s1_time;
            r_s2_q    <= r_s1_q;
            r_s2_rem  <= n_rem;
        end
    end

    // ---------------------------------------------------------------
    // stage 3: time state update, while not stalled one beat per cycle
    // ---------------------------------------------------------------
    logic [SEC_W-1:0]  r_sec,   n_sec;
    logic [MS_W-1:0]   r_milli, n_milli;
    logic [PRE_W-1:0]  r_pre,   n_pre;
    logic              st_en;
    logic [PRE_W-1:0]  pre_next;
    logic              pre_hit;
    logic [MS_W-1:0]   tick_step;
    logic [MS_W-1:0]   ms_inc;
    logic [QUO_W-1:0]  sec_inc;
    logic              do_adv;
    logic [MSUM_W-1:0] ms_sum;
    logic              ms_wrap;
    logic [MS_W-1:0]   ms_norm;

    assign st_en = rdy3 && r_v2;

    always_comb begin
        n_sec    = r_sec;
        n_milli  = r_milli;
        n_pre    = r_pre;
        ms_inc   = '0;
        sec_inc  = '0;
        do_adv   = 1'b0;
        pre_next = r_pre + PRE_W'(1);
        pre_hit  = pre_next >= cfg.ticks_per_ms;
        // a step beyond one second is clipped so one carry always suffices
        tick_step = (cfg.ms_per_tick > MS_W'(MS_PER_SECOND))
                  ? MS_W'(MS_PER_SECOND) : cfg.ms_per_tick;

        unique case (r_s2_mode)
            MODE_TICK: begin
                do_adv = 1'b1;
                if (cfg.ms_per_tick != '0) begin
                    ms_inc = tick_step;
                end else if (cfg.ticks_per_ms > PRE_W'(1)) begin
                    // prescaler: count up, one ms and clear on reaching the limit
                    ms_inc = MS_W'(pre_hit);
                    n_pre  = pre_hit ? '0 : pre_next;
                end else begin
                    ms_inc = MS_W'(1);
                end
            end
            MODE_SET: begin
                n_sec   = r_s2_time;
                n_milli = '0;
            end
            MODE_ADD: begin
                // add_ms split into whole seconds and a sub-second part
                do_adv  = 1'b1;
                ms_inc  = r_s2_rem;
                sec_inc = r_s2_q;
            end
            default: begin
                // read only, state kept
            end
        endcase

        ms_sum  = {1'b0, r_milli} + {1'b0, ms_inc};
        ms_wrap = ms_sum >= MSUM_W'(MS_PER_SECOND);
        ms_norm = ms_wrap ? MS_W'(ms_sum - MSUM_W'(MS_PER_SECOND)) : ms_sum[MS_W-1:0];

        if (do_adv) begin
            n_milli = ms_norm;
            n_sec   = r_sec + SEC_W'(sec_inc) + SEC_W'(ms_wrap);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec   <= '0;
            r_milli <= '0;
            r_pre   <= '0;
        end else if (st_en) begin
            r_sec   <= n_sec;
            r_milli <= n_milli;
            r_pre   <= n_pre;
        end
    end

    // ---------------------------------------------------------------
    // stage 4: result register with the total in milliseconds
    // ---------------------------------------------------------------
    logic [TOTAL_W-1:0] tot_sec;
    logic [TOTAL_W-1:0] n_total;
    logic [SEC_W-1:0]   r_out_sec;
    logic [MS_W-1:0]    r_out_milli;
    logic [TOTAL_W-1:0] r_out_total;

    // times one thousand as 1024 - 16 - 8
    assign tot_sec = TOTAL_W'(r_sec);
    assign n_total = (tot_sec << 10) - (tot_sec << 4) - (tot_sec << 3)
                   + TOTAL_W'(r_milli);

    always_ff @(posedge i_clk) begin
        if (rdy4 && r_v3) begin
            r_out_sec   <= r_sec;
            r_out_milli <= r_milli;
            r_out_total <= n_total;
        end
    end

    assign o_out.valid       = r_v4;
    assign o_out.seconds     = r_out_sec;
    assign o_out.millis_part = r_out_milli;
    assign o_out.total_ms    = r_out_total;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    a_milli_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_milli < MS_W'(MS_PER_SECOND))
        else $error("millisecond part out of range");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> r_s2_rem < MS_W'(MS_PER_SECOND))
        else $error("add_ms remainder out of range");

    a_set_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_en && r_s2_mode == MODE_SET |=> r_milli == '0)
        else $error("set beat left a nonzero millisecond part");

    a_pre_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_en && r_s2_mode != MODE_TICK |=> $stable(r_pre))
        else $error("prescaler moved on a non-tick beat");

    a_read_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_en && r_s2_mode == MODE_READ |=> $stable(r_sec) && $stable(r_milli))
        else $error("read beat changed the time");

endmodule
